>>> hdl/xld_pkg.sv
// Package for the Xiph lacing decoder: transaction payload structs, phase and
// status codes, and the widths of the size arithmetic. No dependencies.
package xld_pkg;

    // Width of one block size and of the sum of all sized blocks of a frame.
    localparam int SIZE_BITS  = 16;
    localparam int SLEFT_BITS = SIZE_BITS + 8;

    // Size table: one entry per sized block, 255 at most, plus one spare slot
    // so that the read pointer may run one entry past the end.
    localparam int TABLE_DEPTH = 255;
    localparam int MEM_DEPTH   = 256;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
    localparam int ENT_BITS    = 8 + SIZE_BITS;

    localparam logic [7:0] RUN_BYTE = 8'd255;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_SIZES = 2'd1,
        PH_DATA  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_END_SIZES   = 2'd1,
        ST_END_BLOCK   = 2'd2,
        ST_OVERFLOW    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic       has_data;
        logic [7:0] payload_byte;
        logic [7:0] block_number;
        logic       block_done;
        logic       frame_done;
        logic [1:0] status;
    } t_out_item;

    // One size table entry: the block index and its non-zero size.
    typedef struct packed {
        logic [7:0]           blk;
        logic [SIZE_BITS-1:0] size;
    } t_entry;

endpackage

>>> hdl/xiph_lace_decoder.sv
// Xiph lacing decoder top level: parses laced frames byte by byte and emits
// tagged payload bytes. Depends on xld_pkg.
//
// The decoder takes one frame byte per clock cycle while the output is not held
// back, with no gaps at block or frame boundaries. Each accepted byte yields at
// most one result in the output register; the input stays ready while that
// register is empty or is being emptied. Block sizes are kept in a 256 x 24
// bit single-port-write memory with a registered read. Only blocks of non-zero
// size are stored, together with their block index, so zero-length blocks are
// skipped without input gaps. The current block's entry is read in the cycle
// before use; a size written on the same edge as it is read is forwarded.
// The memory needs no clearing after reset: entries are only read after being
// written within the same frame. After an error on a byte that is not the last
// of its frame, the remaining bytes of that frame are accepted and dropped.
module xiph_lace_decoder
    import xld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Control state.
    t_phase                r_phase,       n_phase;
    logic [7:0]            r_blocks_lo,   n_blocks_lo;
    logic [7:0]            r_sizes_read,  n_sizes_read;
    logic [SIZE_BITS-1:0]  r_size_sum,    n_size_sum;
    logic [SLEFT_BITS-1:0] r_sized_left,  n_sized_left;
    logic [SIZE_BITS-1:0]  r_bytes_left,  n_bytes_left;
    logic [7:0]            r_cur_blk,     n_cur_blk;
    logic [ADDR_BITS-1:0]  r_nz_cnt,      n_nz_cnt;
    logic [ADDR_BITS-1:0]  r_rd_ptr,      n_rd_ptr;
    logic [7:0]            r_first_idx,   n_first_idx;
    logic                  r_fresh,       n_fresh;
    logic                  r_discard,     n_discard;
    logic                  r_out_valid,   n_out_valid;
    t_out_item             r_out_data,    n_out_data;

    // Size memory and its read/forward path.
    t_entry                r_mem [MEM_DEPTH];
    t_entry                r_mem_q;
    t_entry                r_fwd_data;
    logic                  r_fwd_valid;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    t_entry                wr_data;
    t_entry                cur_ent;

    // Datapath helpers.
    logic                  accept;
    logic [SIZE_BITS:0]    sum_ext;
    logic [SLEFT_BITS-1:0] sized_new;
    logic [SIZE_BITS-1:0]  cur_size;
    logic [SIZE_BITS-1:0]  left_after;
    logic [7:0]            cur_idx;
    logic                  in_sized;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The current entry comes from the memory, or from the write on the
    // previous edge when that write hit the address being read.
    assign cur_ent    = r_fwd_valid ? r_fwd_data : r_mem_q;
    assign cur_size   = r_fresh ? cur_ent.size : r_bytes_left;
    assign cur_idx    = r_fresh ? cur_ent.blk : r_cur_blk;
    assign left_after = cur_size - SIZE_BITS'(1);
    assign in_sized   = (r_sized_left != '0);

    assign sum_ext   = {1'b0, r_size_sum} + {{(SIZE_BITS - 7){1'b0}}, i_in_data.frame_byte};
    assign sized_new = r_sized_left + {{(SLEFT_BITS - SIZE_BITS){1'b0}}, sum_ext[SIZE_BITS-1:0]};

    // Next state and result.
    always_comb begin
        n_phase      = r_phase;
        n_blocks_lo  = r_blocks_lo;
        n_sizes_read = r_sizes_read;
        n_size_sum   = r_size_sum;
        n_sized_left = r_sized_left;
        n_bytes_left = r_bytes_left;
        n_cur_blk    = r_cur_blk;
        n_nz_cnt     = r_nz_cnt;
        n_rd_ptr     = r_rd_ptr;
        n_first_idx  = r_first_idx;
        n_fresh      = r_fresh;
        n_discard    = r_discard;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        wr_en        = 1'b0;
        wr_addr      = r_nz_cnt;
        wr_data      = '{blk: r_sizes_read, size: sum_ext[SIZE_BITS-1:0]};

        if (accept) begin
            // A closing result without data; fields are overridden below.
            n_out_data = '{has_data: 1'b0, payload_byte: 8'd0, block_number: 8'd0,
                           block_done: 1'b0, frame_done: 1'b1, status: ST_OK};
            if (r_discard) begin
                if (i_in_data.frame_end) begin
                    n_discard = 1'b0;
                end
            end else begin
                case (r_phase)
                    PH_COUNT: begin
                        n_blocks_lo  = i_in_data.frame_byte;
                        n_sizes_read = 8'd0;
                        n_size_sum   = '0;
                        n_sized_left = '0;
                        n_cur_blk    = 8'd0;
                        n_nz_cnt     = '0;
                        n_rd_ptr     = '0;
                        if (i_in_data.frame_end) begin
                            n_out_valid       = 1'b1;
                            n_out_data.status = (i_in_data.frame_byte == 8'd0) ?
                                                ST_OK : ST_END_SIZES;
                        end else if (i_in_data.frame_byte == 8'd0) begin
                            n_phase = PH_DATA;
                            n_fresh = 1'b1;
                        end else begin
                            n_phase = PH_SIZES;
                        end
                    end
                    PH_SIZES: begin
                        if (sum_ext[SIZE_BITS]) begin
                            n_out_valid       = 1'b1;
                            n_out_data.status = ST_OVERFLOW;
                            n_discard         = !i_in_data.frame_end;
                            n_phase           = PH_COUNT;
                        end else if (i_in_data.frame_byte == RUN_BYTE) begin
                            n_size_sum = sum_ext[SIZE_BITS-1:0];
                            if (i_in_data.frame_end) begin
                                n_out_valid       = 1'b1;
                                n_out_data.status = ST_END_SIZES;
                                n_phase           = PH_COUNT;
                            end
                        end else begin
                            // A size is complete; only non-zero sizes are stored.
                            if (sum_ext[SIZE_BITS-1:0] != '0) begin
                                wr_en    = 1'b1;
                                n_nz_cnt = r_nz_cnt + ADDR_BITS'(1);
                                if (r_nz_cnt == '0) begin
                                    n_first_idx = r_sizes_read;
                                end
                            end
                            n_sized_left = sized_new;
                            n_sizes_read = r_sizes_read + 8'd1;
                            n_size_sum   = '0;
                            if (n_sizes_read < r_blocks_lo) begin
                                if (i_in_data.frame_end) begin
                                    n_out_valid       = 1'b1;
                                    n_out_data.status = ST_END_SIZES;
                                    n_phase           = PH_COUNT;
                                end
                            end else if (i_in_data.frame_end) begin
                                // Frame closes right after the sizes.
                                n_out_valid             = 1'b1;
                                n_out_data.status       = (sized_new != '0) ?
                                                          ST_END_BLOCK : ST_OK;
                                n_out_data.block_number = (r_nz_cnt != '0) ? r_first_idx :
                                    (sum_ext[SIZE_BITS-1:0] != '0) ? r_sizes_read :
                                    r_blocks_lo;
                                n_phase                 = PH_COUNT;
                            end else begin
                                n_phase  = PH_DATA;
                                n_rd_ptr = '0;
                                n_fresh  = 1'b1;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (in_sized) begin
                            if (i_in_data.frame_end && (r_sized_left > SLEFT_BITS'(1))) begin
                                n_out_valid             = 1'b1;
                                n_out_data.status       = ST_END_BLOCK;
                                n_out_data.block_number = cur_idx;
                                n_phase                 = PH_COUNT;
                            end else begin
                                n_sized_left = r_sized_left - SLEFT_BITS'(1);
                                n_out_valid  = 1'b1;
                                n_out_data   = '{has_data: 1'b1,
                                                 payload_byte: i_in_data.frame_byte,
                                                 block_number: cur_idx,
                                                 block_done: (left_after == '0),
                                                 frame_done: i_in_data.frame_end,
                                                 status: ST_OK};
                                if (i_in_data.frame_end) begin
                                    n_phase = PH_COUNT;
                                end else if (left_after == '0) begin
                                    n_rd_ptr = r_rd_ptr + ADDR_BITS'(1);
                                    n_fresh  = 1'b1;
                                end else begin
                                    n_bytes_left = left_after;
                                    n_cur_blk    = cur_idx;
                                    n_fresh      = 1'b0;
                                end
                            end
                        end else begin
                            // Last block: takes the rest of the frame.
                            n_out_valid = 1'b1;
                            n_out_data  = '{has_data: 1'b1,
                                            payload_byte: i_in_data.frame_byte,
                                            block_number: r_blocks_lo,
                                            block_done: i_in_data.frame_end,
                                            frame_done: i_in_data.frame_end,
                                            status: ST_OK};
                            if (i_in_data.frame_end) begin
                                n_phase = PH_COUNT;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_COUNT;
                    end
                endcase
            end
        end

        // Every new frame starts from an empty size list.
        if (n_phase == PH_COUNT) begin
            n_sizes_read = 8'd0;
            n_size_sum   = '0;
            n_sized_left = '0;
            n_cur_blk    = 8'd0;
            n_nz_cnt     = '0;
            n_rd_ptr     = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_COUNT;
            r_blocks_lo  <= 8'd0;
            r_sizes_read <= 8'd0;
            r_size_sum   <= '0;
            r_sized_left <= '0;
            r_bytes_left <= '0;
            r_cur_blk    <= 8'd0;
            r_nz_cnt     <= '0;
            r_rd_ptr     <= '0;
            r_first_idx  <= 8'd0;
            r_fresh      <= 1'b0;
            r_discard    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fwd_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_blocks_lo  <= n_blocks_lo;
            r_sizes_read <= n_sizes_read;
            r_size_sum   <= n_size_sum;
            r_sized_left <= n_sized_left;
            r_bytes_left <= n_bytes_left;
            r_cur_blk    <= n_cur_blk;
            r_nz_cnt     <= n_nz_cnt;
            r_rd_ptr     <= n_rd_ptr;
            r_first_idx  <= n_first_idx;
            r_fresh      <= n_fresh;
            r_discard    <= n_discard;
            r_out_valid  <= n_out_valid;
            r_fwd_valid  <= wr_en && (wr_addr == n_rd_ptr);
        end
    end

    // Result register and forwarded write data.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_fwd_data <= wr_data;
    end

    // Size memory: one write port, one registered read of the next entry.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[n_rd_ptr];
    end

endmodule
